// ----- design/box_blur_3x3_edge_normalized_core_assert.svh -----
// assertion macros for the box blur core
// no dependencies; the including module provides clock and reset
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define BB3_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("box blur check failed");

// antecedent implies consequent in the same cycle
`define BB3_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box blur check failed");

`endif

// ----- design/bb3_pkg.sv -----
// shared types, constants and the reciprocal table of the box blur core
// no dependencies
package bb3_pkg;

   // pixel and field widths
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int PIX_W       = CHAN_W * NUM_CHAN;
   localparam int TAPS        = 9;
   localparam int SUM_W       = 12;
   localparam int ACC_W       = 13;
   localparam int COUNT_W     = 4;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = ACC_W + RECIP_W;

   // configuration register widths and limits
   localparam int FW_W        = 11;
   localparam int FH_W        = 13;
   localparam int ROW_W       = 12;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int WIDTH_REG_MAX = 2047;
   localparam logic [FH_W-1:0] HEIGHT_MAX   = 13'd4096;
   localparam int              WIDTH_RESET  = 640;
   localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // nine taps of one colour channel, row * 3 + column
   typedef logic [TAPS-1:0][CHAN_W-1:0] taps_type;

   // 3x3 window of full pixels, row * 3 + column, column 2 newest
   typedef logic [TAPS-1:0][PIX_W-1:0] window_type;

   // per-channel means from the lanes
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] means_type;

   // control shared by all lanes
   typedef struct packed {
      logic                    sum_en;
      logic                    mul_en;
      logic [TAPS-1:0]         mask;
      logic [COUNT_W-1:0]      count;
      logic [RECIP_W-1:0]      recip;
   } lane_ctrl_type;

   // ceil(2^18 / (2 * count)) for the neighbourhood sizes that occur
   function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 18'd131072;
         4'd2:    r = 18'd65536;
         4'd3:    r = 18'd43691;
         4'd4:    r = 18'd32768;
         4'd6:    r = 18'd21846;
         4'd9:    r = 18'd14564;
         default: r = 18'd131072;
      endcase
      return r;
   endfunction

endpackage

// ----- design/box_blur_3x3_edge_normalized_core.sv -----
// channel   | direction | handshake           | payload
// req       | in        | req_tvalid/tready   | tdata: red, green, blue; tuser: drain flag
// rsp       | out       | rsp_tvalid/tready   | tdata: red, green, blue; tlast: end of frame
// csr       | in        | csr_we              | csr_addr register index, csr_wdata value
//
// An ignored drain (before the frame's last pixel) is handled in the idle state alone;
// an item without a result passes the line buffer read and the window shift; an item
// with a result passes line buffer read, window shift, lane sum, lane multiply and
// hand-over to the result register. The hand-over waits while the result register is
// full and not being taken; the next item is accepted as soon as the hand-over is done.
// Reset is synchronous; no clearing pass, line buffers are written before use.
// Top level of the 3x3 box blur; depends on bb3_pkg, bb3_line_buf, bb3_lane, bb3_merge
`include "box_blur_3x3_edge_normalized_core_assert.svh"

module box_blur_3x3_edge_normalized_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bb3_pkg::PIX_W-1:0]           req_tdata,
   // req_tuser: cmd [0]
   input  logic                                req_tuser,
   // rsp_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bb3_pkg::PIX_W-1:0]           rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]     csr_addr,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bb3_pkg::*;

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (AW + 1 > FW_W) ? AW + 1 : FW_W;
   localparam int WCAP = (MAX_WIDTH < WIDTH_REG_MAX) ? MAX_WIDTH : WIDTH_REG_MAX;
   localparam logic [FW_W-1:0] WCAP_V  = FW_W'(WCAP);
   localparam logic [FW_W-1:0] WRESET  = FW_W'((WIDTH_RESET > WCAP) ? WCAP : WIDTH_RESET);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM,
      ST_MUL,
      ST_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [FW_W-1:0]    width_ff, width_in;
   logic [FH_W-1:0]    height_ff, height_in;
   logic [AW-1:0]      in_col_ff, in_col_in;
   logic [FH_W-1:0]    in_row_ff, in_row_in;
   logic [AW-1:0]      out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [PIX_W-1:0]   px_ff, px_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic               emit_ff, emit_in;
   logic               last_ff, last_in;
   logic [TAPS-1:0]    mask_ff, mask_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   window_type         window_ff, window_in;

   logic               req_accept;
   logic               in_frame;
   logic               take;
   logic               in_col_last;
   logic               emit_now;
   logic               up, dn, lf, rt;
   logic               frame_end;
   logic [2:0]         row_ok, col_ok;
   logic [TAPS-1:0]    mask_now;
   logic [COUNT_W-1:0] count_now;
   logic [FW_W-1:0]    width_wr;
   logic [FH_W-1:0]    height_wr;
   logic [PIX_W-1:0]   rd_upper, rd_middle;
   logic               rsp_free;
   lane_ctrl_type      lane_ctrl;
   means_type          means;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // frame position of the next input slot
   assign in_frame    = in_row_ff < height_ff;
   assign take        = req_accept && !(in_frame && req_tuser);
   assign in_col_last = (CMPW'(in_col_ff) + CMPW'(1)) >= CMPW'(width_ff);
   assign emit_now    = !((in_row_ff == '0) ||
                          (in_row_ff == FH_W'(1) && in_col_ff == '0));

   // neighbourhood of the next result
   assign up        = out_row_ff != '0;
   assign dn        = (FH_W'(out_row_ff) + FH_W'(1)) < height_ff;
   assign lf        = out_col_ff != '0;
   assign rt        = (CMPW'(out_col_ff) + CMPW'(1)) < CMPW'(width_ff);
   assign frame_end = !rt && !dn;
   assign row_ok    = {dn, 1'b1, up};
   assign col_ok    = {rt, 1'b1, lf};
   assign count_now = (COUNT_W'(2'd1) + COUNT_W'(up) + COUNT_W'(dn)) *
                      (COUNT_W'(2'd1) + COUNT_W'(lf) + COUNT_W'(rt));

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            mask_now[r*3 + k] = row_ok[r] & col_ok[k];
         end
      end
   end

   // size registers clamped on write
   always_comb begin
      width_wr = csr_wdata[FW_W-1:0];
      if (width_wr == '0) begin
         width_wr = FW_W'(1);
      end else if (width_wr > WCAP_V) begin
         width_wr = WCAP_V;
      end
      height_wr = csr_wdata[FH_W-1:0];
      if (height_wr == '0) begin
         height_wr = FH_W'(1);
      end else if (height_wr > HEIGHT_MAX) begin
         height_wr = HEIGHT_MAX;
      end
   end

   // sequencer and position counters
   always_comb begin
      state_in   = state_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      px_in      = px_ff;
      wr_addr_in = wr_addr_ff;
      emit_in    = emit_ff;
      last_in    = last_ff;
      mask_in    = mask_ff;
      count_in   = count_ff;
      window_in  = window_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               px_in      = in_frame ? req_tdata : '0;
               wr_addr_in = in_col_ff;
               emit_in    = emit_now;
               if (in_col_last) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + FH_W'(1);
               end else begin
                  in_col_in = in_col_ff + AW'(1);
               end
               if (emit_now) begin
                  mask_in  = mask_now;
                  count_in = count_now;
                  last_in  = frame_end;
                  if (!rt) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + ROW_W'(1);
                  end else begin
                     out_col_in = out_col_ff + AW'(1);
                  end
                  if (frame_end) begin
                     in_col_in  = '0;
                     in_row_in  = '0;
                     out_col_in = '0;
                     out_row_in = '0;
                  end
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            for (int r = 0; r < 3; r++) begin
               window_in[r*3]     = window_ff[r*3 + 1];
               window_in[r*3 + 1] = window_ff[r*3 + 2];
            end
            window_in[2] = rd_upper;
            window_in[5] = rd_middle;
            window_in[8] = px_ff;
            state_in = emit_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a register write restarts the frame
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  width_in  = width_wr;
            CSR_FRAME_HEIGHT: height_in = height_wr;
            default: begin
            end
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= WRESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         emit_ff    <= 1'b0;
         window_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         emit_ff    <= emit_in;
         window_ff  <= window_in;
      end
      px_ff      <= px_in;
      wr_addr_ff <= wr_addr_in;
      last_ff    <= last_in;
      mask_ff    <= mask_in;
      count_ff   <= count_in;
   end

   // line buffers: read when an accepted item is taken in (not on an ignored drain), written back during the shift
   bb3_line_buf #(.DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (state_ff == ST_SHIFT),
      .wr_addr (wr_addr_ff),
      .wr_data (rd_middle),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (rd_upper)
   );

   bb3_line_buf #(.DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (state_ff == ST_SHIFT),
      .wr_addr (wr_addr_ff),
      .wr_data (px_ff),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (rd_middle)
   );

   // one lane per colour channel
   assign lane_ctrl.sum_en = (state_ff == ST_SUM);
   assign lane_ctrl.mul_en = (state_ff == ST_MUL);
   assign lane_ctrl.mask   = mask_ff;
   assign lane_ctrl.count  = count_ff;
   assign lane_ctrl.recip  = recip_of(count_ff);

   for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
      taps_type taps;
      always_comb begin
         for (int k = 0; k < TAPS; k++) begin
            taps[k] = window_ff[k][ch*CHAN_W +: CHAN_W];
         end
      end
      bb3_lane u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .taps  (taps),
         .mean  (means[ch])
      );
   end

   // result register
   bb3_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       ((state_ff == ST_PUSH) && rsp_free),
      .means      (means),
      .last       (last_ff),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // input column and output row counters stay inside the frame
   `BB3_ASSERT_ALWAYS(a_in_col_range, CMPW'(in_col_ff) < CMPW'(width_ff))
   `BB3_ASSERT_ALWAYS(a_out_row_range, FH_W'(out_row_ff) < height_ff)
   // a result only appears after the hand-over state
   `BB3_ASSERT_IMPLY(a_rsp_from_push, $rose(rsp_tvalid), $past(state_ff) == ST_PUSH)

endmodule

// ----- design/bb3_line_buf.sv -----
// one line buffer: single write port, single read port with registered data
// depends on bb3_pkg for the pixel width
module bb3_line_buf #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [bb3_pkg::PIX_W-1:0]         wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [bb3_pkg::PIX_W-1:0]         rd_data
);
   import bb3_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bb3_lane.sv -----
// one colour lane: masked 3x3 sum, then rounded mean by reciprocal multiply
// depends on bb3_pkg for the lane control struct and widths
module bb3_lane (
   input  logic                       clock,
   input  bb3_pkg::lane_ctrl_type     ctrl,
   input  bb3_pkg::taps_type          taps,
   output logic [bb3_pkg::CHAN_W-1:0] mean
);
   import bb3_pkg::*;

   logic [SUM_W-1:0]   sum;
   logic [ACC_W-1:0]   acc_in;
   logic [ACC_W-1:0]   acc_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [PROD_W-1:0]  prod;
   logic [CHAN_W-1:0]  mean_ff;

   // sum of the taps that lie inside the frame
   always_comb begin
      sum = '0;
      for (int k = 0; k < TAPS; k++) begin
         if (ctrl.mask[k]) begin
            sum = sum + SUM_W'(taps[k]);
         end
      end
   end

   // 2 * sum + count
   assign acc_in = {sum, 1'b0} + ACC_W'(ctrl.count);

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         acc_ff   <= acc_in;
         recip_ff <= ctrl.recip;
      end
   end

   // divide by 2 * count through the reciprocal
   assign prod = PROD_W'(acc_ff) * PROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         mean_ff <= prod[RECIP_SHIFT +: CHAN_W];
      end
   end

   assign mean = mean_ff;

endmodule

// ----- design/bb3_merge.sv -----
// merge stage: packs the three lane means into the result register
// depends on bb3_pkg for the means type
module bb3_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  bb3_pkg::means_type         means,
   input  logic                       last,
   output logic                       free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);
   import bb3_pkg::*;

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] data_ff, data_in;
   logic             last_ff, last_in;

   // result register is free when empty or being taken
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = means;
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule
